/* src/rvd_pkg.sv */
// Shared types and constants for the RV32I instruction decoder.
// No dependencies; every other file takes its names by rvd_pkg:: scope.
package rvd_pkg;

    localparam int XLEN  = 32;
    localparam int OP_W  = 6;
    localparam int REG_W = 5;

    // Major opcodes, instruction bits 6..0
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [XLEN-1:0] WORD_ECALL  = 32'h0000_0073;
    localparam logic [XLEN-1:0] WORD_EBREAK = 32'h0010_0073;

    // Mnemonic indexes
    localparam logic [OP_W-1:0] OP_LUI    = 6'd0;
    localparam logic [OP_W-1:0] OP_AUIPC  = 6'd1;
    localparam logic [OP_W-1:0] OP_JAL    = 6'd2;
    localparam logic [OP_W-1:0] OP_JALR   = 6'd3;
    localparam logic [OP_W-1:0] OP_BEQ    = 6'd4;
    localparam logic [OP_W-1:0] OP_BNE    = 6'd5;
    localparam logic [OP_W-1:0] OP_BLT    = 6'd6;
    localparam logic [OP_W-1:0] OP_BGE    = 6'd7;
    localparam logic [OP_W-1:0] OP_BLTU   = 6'd8;
    localparam logic [OP_W-1:0] OP_BGEU   = 6'd9;
    localparam logic [OP_W-1:0] OP_LB     = 6'd10;
    localparam logic [OP_W-1:0] OP_LH     = 6'd11;
    localparam logic [OP_W-1:0] OP_LW     = 6'd12;
    localparam logic [OP_W-1:0] OP_LBU    = 6'd13;
    localparam logic [OP_W-1:0] OP_LHU    = 6'd14;
    localparam logic [OP_W-1:0] OP_SB     = 6'd15;
    localparam logic [OP_W-1:0] OP_SH     = 6'd16;
    localparam logic [OP_W-1:0] OP_SW     = 6'd17;
    localparam logic [OP_W-1:0] OP_ADDI   = 6'd18;
    localparam logic [OP_W-1:0] OP_SLTI   = 6'd19;
    localparam logic [OP_W-1:0] OP_SLTIU  = 6'd20;
    localparam logic [OP_W-1:0] OP_XORI   = 6'd21;
    localparam logic [OP_W-1:0] OP_ORI    = 6'd22;
    localparam logic [OP_W-1:0] OP_ANDI   = 6'd23;
    localparam logic [OP_W-1:0] OP_SLLI   = 6'd24;
    localparam logic [OP_W-1:0] OP_SRLI   = 6'd25;
    localparam logic [OP_W-1:0] OP_SRAI   = 6'd26;
    localparam logic [OP_W-1:0] OP_ADD    = 6'd27;
    localparam logic [OP_W-1:0] OP_SUB    = 6'd28;
    localparam logic [OP_W-1:0] OP_SLL    = 6'd29;
    localparam logic [OP_W-1:0] OP_SLT    = 6'd30;
    localparam logic [OP_W-1:0] OP_SLTU   = 6'd31;
    localparam logic [OP_W-1:0] OP_XOR    = 6'd32;
    localparam logic [OP_W-1:0] OP_SRL    = 6'd33;
    localparam logic [OP_W-1:0] OP_SRA    = 6'd34;
    localparam logic [OP_W-1:0] OP_OR     = 6'd35;
    localparam logic [OP_W-1:0] OP_AND    = 6'd36;
    localparam logic [OP_W-1:0] OP_ECALL  = 6'd37;
    localparam logic [OP_W-1:0] OP_EBREAK = 6'd38;
    localparam logic [OP_W-1:0] OP_CSRRW  = 6'd39;
    localparam logic [OP_W-1:0] OP_CSRRS  = 6'd40;
    localparam logic [OP_W-1:0] OP_CSRRC  = 6'd41;
    localparam logic [OP_W-1:0] OP_CSRRWI = 6'd42;
    localparam logic [OP_W-1:0] OP_CSRRSI = 6'd43;
    localparam logic [OP_W-1:0] OP_CSRRCI = 6'd44;

    typedef struct packed {
        logic                    illegal;
        logic [OP_W-1:0]         op_code;
        logic [REG_W-1:0]        dest_reg;
        logic [REG_W-1:0]        src1_reg;
        logic [REG_W-1:0]        src2_reg;
        logic signed [XLEN-1:0]  immediate;
        logic [XLEN-1:0]         target;
    } result_t;

endpackage

/* src/rvd_decode.sv */
// Combinational RV32I decode: mnemonic, register fields, immediate, target.
// Depends on rvd_pkg.
module rvd_decode
(
    input  logic [rvd_pkg::XLEN-1:0] pc_address,
    input  logic [rvd_pkg::XLEN-1:0] instruction,
    output rvd_pkg::result_t         result
);

    logic [6:0]               opc;
    logic [2:0]               f3;
    logic [6:0]               f7;
    logic [rvd_pkg::XLEN-1:0] imm_i;
    logic [rvd_pkg::XLEN-1:0] imm_s;
    logic [rvd_pkg::XLEN-1:0] imm_b;
    logic [rvd_pkg::XLEN-1:0] imm_j;
    logic [rvd_pkg::XLEN-1:0] imm_u;
    logic [rvd_pkg::XLEN-1:0] imm_hi12;
    logic [rvd_pkg::XLEN-1:0] imm_shamt;
    rvd_pkg::result_t         res;
    logic                     ok;

    assign opc = instruction[6:0];
    assign f3  = instruction[14:12];
    assign f7  = instruction[31:25];

    assign imm_i = {{20{instruction[31]}}, instruction[31:20]};
    assign imm_s = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
    assign imm_b = {{19{instruction[31]}}, instruction[31], instruction[7],
                    instruction[30:25], instruction[11:8], 1'b0};
    assign imm_j = {{11{instruction[31]}}, instruction[31], instruction[19:12],
                    instruction[20], instruction[30:21], 1'b0};
    assign imm_u     = {12'd0, instruction[31:12]};
    assign imm_hi12  = {20'd0, instruction[31:20]};
    assign imm_shamt = {27'd0, instruction[24:20]};

    always_comb
    begin
        res = '0;
        ok  = 1'b1;
        case (opc)
            rvd_pkg::OPC_LUI:
            begin
                res.op_code   = rvd_pkg::OP_LUI;
                res.dest_reg  = instruction[11:7];
                res.immediate = imm_u;
            end
            rvd_pkg::OPC_AUIPC:
            begin
                res.op_code   = rvd_pkg::OP_AUIPC;
                res.dest_reg  = instruction[11:7];
                res.immediate = imm_u;
            end
            rvd_pkg::OPC_JAL:
            begin
                res.op_code   = rvd_pkg::OP_JAL;
                res.dest_reg  = instruction[11:7];
                res.immediate = imm_j;
                res.target    = pc_address + imm_j;
            end
            rvd_pkg::OPC_JALR:
            begin
                // funct3 left unchecked
                res.op_code   = rvd_pkg::OP_JALR;
                res.dest_reg  = instruction[11:7];
                res.src1_reg  = instruction[19:15];
                res.immediate = imm_i;
            end
            rvd_pkg::OPC_BRANCH:
            begin
                res.src1_reg  = instruction[19:15];
                res.src2_reg  = instruction[24:20];
                res.immediate = imm_b;
                res.target    = pc_address + imm_b;
                case (f3)
                    3'd0:    res.op_code = rvd_pkg::OP_BEQ;
                    3'd1:    res.op_code = rvd_pkg::OP_BNE;
                    3'd4:    res.op_code = rvd_pkg::OP_BLT;
                    3'd5:    res.op_code = rvd_pkg::OP_BGE;
                    3'd6:    res.op_code = rvd_pkg::OP_BLTU;
                    3'd7:    res.op_code = rvd_pkg::OP_BGEU;
                    default: ok = 1'b0;
                endcase
            end
            rvd_pkg::OPC_LOAD:
            begin
                res.dest_reg  = instruction[11:7];
                res.src1_reg  = instruction[19:15];
                res.immediate = imm_i;
                case (f3)
                    3'd0:    res.op_code = rvd_pkg::OP_LB;
                    3'd1:    res.op_code = rvd_pkg::OP_LH;
                    3'd2:    res.op_code = rvd_pkg::OP_LW;
                    3'd4:    res.op_code = rvd_pkg::OP_LBU;
                    3'd5:    res.op_code = rvd_pkg::OP_LHU;
                    default: ok = 1'b0;
                endcase
            end
            rvd_pkg::OPC_STORE:
            begin
                res.src1_reg  = instruction[19:15];
                res.src2_reg  = instruction[24:20];
                res.immediate = imm_s;
                case (f3)
                    3'd0:    res.op_code = rvd_pkg::OP_SB;
                    3'd1:    res.op_code = rvd_pkg::OP_SH;
                    3'd2:    res.op_code = rvd_pkg::OP_SW;
                    default: ok = 1'b0;
                endcase
            end
            rvd_pkg::OPC_OPIMM:
            begin
                res.dest_reg  = instruction[11:7];
                res.src1_reg  = instruction[19:15];
                res.immediate = imm_i;
                case (f3)
                    3'd0: res.op_code = rvd_pkg::OP_ADDI;
                    3'd2: res.op_code = rvd_pkg::OP_SLTI;
                    3'd3: res.op_code = rvd_pkg::OP_SLTIU;
                    3'd4: res.op_code = rvd_pkg::OP_XORI;
                    3'd6: res.op_code = rvd_pkg::OP_ORI;
                    3'd7: res.op_code = rvd_pkg::OP_ANDI;
                    3'd1:
                    begin
                        // upper bits not checked for slli
                        res.op_code   = rvd_pkg::OP_SLLI;
                        res.immediate = imm_shamt;
                    end
                    default:
                    begin
                        res.immediate = imm_shamt;
                        if (f7 == rvd_pkg::F7_BASE)
                            res.op_code = rvd_pkg::OP_SRLI;
                        else if (f7 == rvd_pkg::F7_ALT)
                            res.op_code = rvd_pkg::OP_SRAI;
                        else
                            ok = 1'b0;
                    end
                endcase
            end
            rvd_pkg::OPC_OP:
            begin
                res.dest_reg = instruction[11:7];
                res.src1_reg = instruction[19:15];
                res.src2_reg = instruction[24:20];
                if (f7 == rvd_pkg::F7_BASE)
                begin
                    case (f3)
                        3'd0:    res.op_code = rvd_pkg::OP_ADD;
                        3'd1:    res.op_code = rvd_pkg::OP_SLL;
                        3'd2:    res.op_code = rvd_pkg::OP_SLT;
                        3'd3:    res.op_code = rvd_pkg::OP_SLTU;
                        3'd4:    res.op_code = rvd_pkg::OP_XOR;
                        3'd5:    res.op_code = rvd_pkg::OP_SRL;
                        3'd6:    res.op_code = rvd_pkg::OP_OR;
                        default: res.op_code = rvd_pkg::OP_AND;
                    endcase
                end
                else if (f7 == rvd_pkg::F7_ALT && f3 == 3'd0)
                    res.op_code = rvd_pkg::OP_SUB;
                else if (f7 == rvd_pkg::F7_ALT && f3 == 3'd5)
                    res.op_code = rvd_pkg::OP_SRA;
                else
                    ok = 1'b0;
            end
            rvd_pkg::OPC_SYSTEM:
            begin
                case (f3)
                    3'd0:
                    begin
                        // only the exact ecall / ebreak words
                        if (instruction == rvd_pkg::WORD_ECALL)
                            res.op_code = rvd_pkg::OP_ECALL;
                        else if (instruction == rvd_pkg::WORD_EBREAK)
                            res.op_code = rvd_pkg::OP_EBREAK;
                        else
                            ok = 1'b0;
                    end
                    3'd4: ok = 1'b0;
                    default:
                    begin
                        res.dest_reg  = instruction[11:7];
                        res.src1_reg  = instruction[19:15];
                        res.immediate = imm_hi12;
                        case (f3)
                            3'd1:    res.op_code = rvd_pkg::OP_CSRRW;
                            3'd2:    res.op_code = rvd_pkg::OP_CSRRS;
                            3'd3:    res.op_code = rvd_pkg::OP_CSRRC;
                            3'd5:    res.op_code = rvd_pkg::OP_CSRRWI;
                            3'd6:    res.op_code = rvd_pkg::OP_CSRRSI;
                            default: res.op_code = rvd_pkg::OP_CSRRCI;
                        endcase
                    end
                endcase
            end
            default: ok = 1'b0;
        endcase

        if (!ok)
        begin
            res         = '0;
            res.illegal = 1'b1;
        end
    end

    assign result = res;

endmodule

/* src/rv32i_instruction_decoder.sv */
// RV32I instruction decoder: one instruction word and its address per request in,
// one decoded result per request out. Throughput is one request per cycle unless a
// stalled result holds the flow; a request passes the input register, then the
// combinational decode into the result register. s_tready follows m_tready through
// the two registered stages, so a stalled result holds the pipeline. No reset-time
// sweep and no configuration. Depends on rvd_pkg and rvd_decode.
module rv32i_instruction_decoder
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] pc_address, [63:32] instruction

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [5:0] op_code, [10:6] dest_reg, [15:11] src1_reg,
                                   // [20:16] src2_reg, [52:21] immediate,
                                   // [84:53] target, [87:85] zero
    output logic        m_tuser    // [0] illegal
);

    logic                     stg_valid_reg;
    logic                     stg_valid_next;
    logic [rvd_pkg::XLEN-1:0] stg_pc_reg;
    logic [rvd_pkg::XLEN-1:0] stg_instr_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    rvd_pkg::result_t         out_res_reg;
    rvd_pkg::result_t         dec_res;
    logic                     adv;
    logic                     take;

    // result stage loads when it is empty or being drained
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = !stg_valid_reg || adv;
    assign take     = s_tvalid && s_tready;

    assign stg_valid_next = take || (stg_valid_reg && !adv);
    assign out_valid_next = (stg_valid_reg && adv) || (out_valid_reg && !m_tready);

    rvd_decode u_decode
    (
        .pc_address  (stg_pc_reg),
        .instruction (stg_instr_reg),
        .result      (dec_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stg_pc_reg    <= s_tdata[31:0];
            stg_instr_reg <= s_tdata[63:32];
        end
        if (stg_valid_reg && adv)
            out_res_reg <= dec_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.illegal;
    assign m_tdata  = {3'b000, out_res_reg.target, out_res_reg.immediate,
                       out_res_reg.src2_reg, out_res_reg.src1_reg,
                       out_res_reg.dest_reg, out_res_reg.op_code};

endmodule

/* src/rvd_checker.sv */
// Port-level checks for the RV32I instruction decoder, bound to the top level.
// Depends on rvd_pkg and rv32i_instruction_decoder.
module rvd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic        m_tuser
);

    // an accepted request shows up as a valid result after the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("accepted request did not reach the output");

    // illegal words carry all-zero fields
    a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 88'd0)
        else $error("illegal result with nonzero fields");

    a_op_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[5:0] <= rvd_pkg::OP_CSRRCI)
        else $error("mnemonic index out of range");

    // only jal and branches produce a target
    a_target_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[84:53] != 32'd0 |->
            m_tdata[5:0] >= rvd_pkg::OP_JAL && m_tdata[5:0] <= rvd_pkg::OP_BGEU &&
            m_tdata[5:0] != rvd_pkg::OP_JALR)
        else $error("target set for a non-jump instruction");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind rv32i_instruction_decoder rvd_checker u_rvd_checker (.*);
